FILE: hdl/integer_text_formatter_core_defines.svh
// Assertion macros shared by the formatter RTL.
`ifndef INTEGER_TEXT_FORMATTER_CORE_DEFINES_SVH
`define INTEGER_TEXT_FORMATTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define ITF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define ITF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/itf_pkg.sv
// Types, constants, character helpers and the control store of the formatter.
package itf_pkg;

   localparam int MAX_FIELD  = 63;
   localparam int NUM_DIGITS = 10;
   localparam logic [31:0] RECIP_10 = 32'hCCCCCCCD;
   localparam int RECIP_SHIFT = 35;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ALPHA = 8'h57;

   typedef logic [3:0] digit_type;
   typedef logic [$clog2(NUM_DIGITS+1)-1:0] dcount_type;
   typedef logic [$clog2(NUM_DIGITS)-1:0] dindex_type;

   typedef enum logic [1:0] {
      KIND_LITERAL = 2'd0,
      KIND_DEC     = 2'd1,
      KIND_HEX     = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_QUOT,
      OP_DIGIT,
      OP_ZEROS,
      OP_SPACES,
      OP_EMIT_SPACE,
      OP_EMIT_SIGN,
      OP_EMIT_ZERO,
      OP_EMIT_DIGIT,
      OP_EMIT_LIT
   } op_type;

   typedef enum logic [2:0] {
      C_NEVER,
      C_NO_ACC,
      C_LITERAL,
      C_NO_DIGITS,
      C_QUOT_NZ,
      C_AGAIN
   } cond_type;

   typedef enum logic [3:0] {
      S_FETCH = 4'd0,
      S_KIND  = 4'd1,
      S_CONV  = 4'd2,
      S_DIVQ  = 4'd3,
      S_DIVR  = 4'd4,
      S_SIZE  = 4'd5,
      S_PAD   = 4'd6,
      S_SPACE = 4'd7,
      S_SIGN  = 4'd8,
      S_ZERO  = 4'd9,
      S_DIGIT = 4'd10,
      S_LIT   = 4'd11
   } step_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
      logic     ret;
   } ucode_type;

   // ASCII for one digit, lower-case hex letters
   function automatic logic [7:0] digit_char(input digit_type d);
      if (d < 4'd10) begin
         digit_char = CHAR_ZERO + {4'b0, d};
      end else begin
         digit_char = CHAR_ALPHA + {4'b0, d};
      end
   endfunction

   // Control store: one word per step; taken cond jumps to target,
   // otherwise ret returns to fetch and a clear ret falls through.
   function automatic ucode_type ucode(input step_type s);
      case (s)
         S_FETCH: ucode = '{OP_LOAD,       C_NO_ACC,    S_FETCH, 1'b0};
         S_KIND:  ucode = '{OP_NOP,        C_LITERAL,   S_LIT,   1'b0};
         S_CONV:  ucode = '{OP_NOP,        C_NO_DIGITS, S_SIZE,  1'b0};
         S_DIVQ:  ucode = '{OP_QUOT,       C_NEVER,     S_FETCH, 1'b0};
         S_DIVR:  ucode = '{OP_DIGIT,      C_QUOT_NZ,   S_DIVQ,  1'b0};
         S_SIZE:  ucode = '{OP_ZEROS,      C_NEVER,     S_FETCH, 1'b0};
         S_PAD:   ucode = '{OP_SPACES,     C_NEVER,     S_FETCH, 1'b0};
         S_SPACE: ucode = '{OP_EMIT_SPACE, C_AGAIN,     S_SPACE, 1'b0};
         S_SIGN:  ucode = '{OP_EMIT_SIGN,  C_NEVER,     S_FETCH, 1'b0};
         S_ZERO:  ucode = '{OP_EMIT_ZERO,  C_AGAIN,     S_ZERO,  1'b0};
         S_DIGIT: ucode = '{OP_EMIT_DIGIT, C_AGAIN,     S_DIGIT, 1'b1};
         S_LIT:   ucode = '{OP_EMIT_LIT,   C_NEVER,     S_FETCH, 1'b1};
         default: ucode = '{OP_NOP,        C_NEVER,     S_FETCH, 1'b1};
      endcase
   endfunction

endpackage

FILE: hdl/itf_if.sv
// Valid/ready channel interfaces for conversion requests and output characters.
interface itf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  char_byte;
   logic [31:0] value;
   logic [5:0]  field_width;
   logic        has_precision;
   logic [5:0]  precision;

   modport source (output valid, kind, char_byte, value, field_width, has_precision,
                   precision, input ready);
   modport sink   (input valid, kind, char_byte, value, field_width, has_precision,
                   precision, output ready);
endinterface

interface itf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_out;
   logic       last;

   modport source (output valid, char_out, last, input ready);
   modport sink   (input valid, char_out, last, output ready);
endinterface

FILE: hdl/integer_text_formatter_core.sv
// Integer text formatter: turns one parsed %d/%x conversion or literal byte into characters.
// A microcoded sequencer walks a 12-word control store; each item is taken in the fetch
// step and its characters leave one per cycle, while the output side does not stall,
// through a single output register, so a result waits there while the sequencer keeps
// going. A conversion runs its digit loop once per digit (1..10 digits, or none for kind
// three), then emits the leading spaces, the sign, the leading zeros and the digits. The
// digit loop uses one 32x32 reciprocal multiply per decimal digit (quotient step, then
// remainder step); the emit loops move one character per cycle unless the output stalls.
// The next item is accepted only after the last character has been issued.
// A literal item goes from the kind step straight to the literal step.
`include "integer_text_formatter_core_defines.svh"

module integer_text_formatter_core (
   input logic       clock,
   input logic       reset,
   itf_req_if.sink   req_bus,
   itf_rsp_if.source rsp_bus
);

   itf_pkg::step_type  step_ff, step_in;
   itf_pkg::ucode_type uw;

   itf_pkg::kind_type  kind_ff, kind_in;
   logic [7:0]         lit_ff, lit_in;
   logic [31:0]        mag_ff, mag_in;
   logic [31:0]        quot_ff, quot_in;
   logic               neg_ff, neg_in;
   logic               zero_ff, zero_in;
   logic [5:0]         fw_ff, fw_in;
   logic               hasp_ff, hasp_in;
   logic [5:0]         prec_ff, prec_in;
   itf_pkg::dcount_type nd_ff, nd_in;
   itf_pkg::digit_type digs_ff [itf_pkg::NUM_DIGITS];
   itf_pkg::digit_type digs_in [itf_pkg::NUM_DIGITS];
   logic [5:0]         zeros_ff, zeros_in;
   logic [5:0]         spaces_ff, spaces_in;
   logic [6:0]         tot_ff, tot_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_char_ff, rsp_char_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [5:0]         cnt;
   logic               emit_req, out_free, emit_fire, stall, accept, taken;
   logic [63:0]        prod;
   logic [31:0]        rem;
   logic [6:0]         used;
   logic [7:0]         char_sel;
   itf_pkg::dindex_type wr_idx, rd_idx;

   logic               in_emit, digit_fire, digit_ok;
   logic [6:0]         left_sum;

   assign uw = itf_pkg::ucode(step_ff);

   assign req_bus.ready = (uw.op == itf_pkg::OP_LOAD);
   assign accept        = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.char_out = rsp_char_ff;
   assign rsp_bus.last     = rsp_last_ff;

   // Count of characters left in the phase of the current emit step
   always_comb begin
      case (uw.op)
         itf_pkg::OP_EMIT_SPACE: cnt = spaces_ff;
         itf_pkg::OP_EMIT_SIGN:  cnt = {5'b0, neg_ff};
         itf_pkg::OP_EMIT_ZERO:  cnt = zeros_ff;
         itf_pkg::OP_EMIT_DIGIT: cnt = 6'(nd_ff);
         itf_pkg::OP_EMIT_LIT:   cnt = 6'd1;
         default:                cnt = 6'd0;
      endcase
   end

   assign emit_req  = (cnt != 6'd0);
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign emit_fire = emit_req && out_free;
   assign stall     = emit_req && !out_free;

   always_comb begin
      case (uw.cond)
         itf_pkg::C_NEVER:     taken = 1'b0;
         itf_pkg::C_NO_ACC:    taken = !accept;
         itf_pkg::C_LITERAL:   taken = (kind_ff == itf_pkg::KIND_LITERAL);
         itf_pkg::C_NO_DIGITS: taken = (kind_ff == itf_pkg::KIND_NONE);
         itf_pkg::C_QUOT_NZ:   taken = (quot_ff != 32'd0);
         itf_pkg::C_AGAIN:     taken = (cnt > 6'd1);
         default:              taken = 1'b0;
      endcase
   end

   // Next step
   always_comb begin
      if (stall) begin
         step_in = step_ff;
      end else if (taken) begin
         step_in = uw.target;
      end else if (uw.ret) begin
         step_in = itf_pkg::S_FETCH;
      end else begin
         step_in = itf_pkg::step_type'(4'(step_ff + 4'd1));
      end
   end

   // Character for the current emit step
   assign rd_idx = (nd_ff == '0) ? '0 : itf_pkg::dindex_type'(nd_ff - 1'b1);

   always_comb begin
      case (uw.op)
         itf_pkg::OP_EMIT_SPACE: char_sel = itf_pkg::CHAR_SPACE;
         itf_pkg::OP_EMIT_SIGN:  char_sel = itf_pkg::CHAR_MINUS;
         itf_pkg::OP_EMIT_ZERO:  char_sel = itf_pkg::CHAR_ZERO;
         itf_pkg::OP_EMIT_DIGIT: char_sel = itf_pkg::digit_char(digs_ff[rd_idx]);
         itf_pkg::OP_EMIT_LIT:   char_sel = lit_ff;
         default:                char_sel = itf_pkg::CHAR_SPACE;
      endcase
   end

   assign prod   = mag_ff * itf_pkg::RECIP_10;
   assign rem    = mag_ff - (quot_ff << 3) - (quot_ff << 1);
   assign used   = 7'(zeros_ff) + 7'(nd_ff) + 7'(neg_ff);
   assign wr_idx = itf_pkg::dindex_type'(nd_ff);

   // Datapath
   always_comb begin
      kind_in   = kind_ff;
      lit_in    = lit_ff;
      mag_in    = mag_ff;
      quot_in   = quot_ff;
      neg_in    = neg_ff;
      zero_in   = zero_ff;
      fw_in     = fw_ff;
      hasp_in   = hasp_ff;
      prec_in   = prec_ff;
      nd_in     = nd_ff;
      digs_in   = digs_ff;
      zeros_in  = zeros_ff;
      spaces_in = spaces_ff;
      tot_in    = tot_ff;

      case (uw.op)
         itf_pkg::OP_LOAD: begin
            if (accept) begin
               kind_in = itf_pkg::kind_type'(req_bus.kind);
               lit_in  = req_bus.char_byte;
               neg_in  = (req_bus.kind == itf_pkg::KIND_DEC) && req_bus.value[31];
               mag_in  = neg_in ? (32'd0 - req_bus.value) : req_bus.value;
               zero_in = (req_bus.value == 32'd0);
               fw_in   = (7'(req_bus.field_width) > 7'(itf_pkg::MAX_FIELD)) ?
                         6'(itf_pkg::MAX_FIELD) : req_bus.field_width;
               prec_in = (7'(req_bus.precision) > 7'(itf_pkg::MAX_FIELD)) ?
                         6'(itf_pkg::MAX_FIELD) : req_bus.precision;
               hasp_in = req_bus.has_precision;
               nd_in   = '0;
            end
         end
         itf_pkg::OP_QUOT: begin
            if (kind_ff == itf_pkg::KIND_HEX) begin
               quot_in = {4'b0, mag_ff[31:4]};
            end else begin
               quot_in = 32'(prod[63:itf_pkg::RECIP_SHIFT]);
            end
         end
         itf_pkg::OP_DIGIT: begin
            digs_in[wr_idx] = (kind_ff == itf_pkg::KIND_HEX) ? mag_ff[3:0] : rem[3:0];
            nd_in  = nd_ff + 1'b1;
            mag_in = quot_ff;
         end
         itf_pkg::OP_ZEROS: begin
            // an explicit zero precision drops the digit of a zero value
            if (hasp_ff && (prec_ff == 6'd0) && zero_ff) begin
               nd_in = '0;
            end
            if ((kind_ff != itf_pkg::KIND_NONE) && hasp_ff && (prec_ff > 6'(nd_ff))) begin
               zeros_in = prec_ff - 6'(nd_ff);
            end else begin
               zeros_in = 6'd0;
            end
         end
         itf_pkg::OP_SPACES: begin
            if (7'(fw_ff) > used) begin
               spaces_in = 6'(7'(fw_ff) - used);
               tot_in    = 7'(fw_ff);
            end else begin
               spaces_in = 6'd0;
               tot_in    = used;
            end
         end
         itf_pkg::OP_EMIT_SPACE: begin
            if (emit_fire) begin
               spaces_in = spaces_ff - 6'd1;
               tot_in    = tot_ff - 7'd1;
            end
         end
         itf_pkg::OP_EMIT_SIGN: begin
            if (emit_fire) begin
               neg_in = 1'b0;
               tot_in = tot_ff - 7'd1;
            end
         end
         itf_pkg::OP_EMIT_ZERO: begin
            if (emit_fire) begin
               zeros_in = zeros_ff - 6'd1;
               tot_in   = tot_ff - 7'd1;
            end
         end
         itf_pkg::OP_EMIT_DIGIT: begin
            if (emit_fire) begin
               nd_in  = nd_ff - 1'b1;
               tot_in = tot_ff - 7'd1;
            end
         end
         default: begin
         end
      endcase
   end

   // Output register
   always_comb begin
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = char_sel;
         rsp_last_in  = (uw.op == itf_pkg::OP_EMIT_LIT) || (tot_ff == 7'd1);
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= itf_pkg::S_FETCH;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      lit_ff      <= lit_in;
      mag_ff      <= mag_in;
      quot_ff     <= quot_in;
      neg_ff      <= neg_in;
      zero_ff     <= zero_in;
      fw_ff       <= fw_in;
      hasp_ff     <= hasp_in;
      prec_ff     <= prec_in;
      nd_ff       <= nd_in;
      digs_ff     <= digs_in;
      zeros_ff    <= zeros_in;
      spaces_ff   <= spaces_in;
      tot_ff      <= tot_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign in_emit    = (step_ff == itf_pkg::S_SPACE) || (step_ff == itf_pkg::S_SIGN) ||
                       (step_ff == itf_pkg::S_ZERO) || (step_ff == itf_pkg::S_DIGIT);
   assign left_sum   = 7'(spaces_ff) + 7'(neg_ff) + 7'(zeros_ff) + 7'(nd_ff);
   assign digit_fire = emit_fire && (uw.op == itf_pkg::OP_EMIT_DIGIT);
   assign digit_ok   = ((rsp_char_ff >= 8'h30) && (rsp_char_ff <= 8'h39)) ||
                       ((rsp_char_ff >= 8'h61) && (rsp_char_ff <= 8'h66));

   `ITF_ASSERT_NEXT(a_accept_to_kind, accept, step_ff == itf_pkg::S_KIND, "accept did not advance")

   `ITF_ASSERT_NOW(a_total_matches, in_emit, tot_ff == left_sum, "character total out of step")

   `ITF_ASSERT_NEXT(a_digit_ascii, digit_fire, digit_ok, "digit is not lower-case ASCII")

endmodule

FILE: sim/integer_text_formatter_core_tb.sv
// Self-checking testbench for integer_text_formatter_core: %d/%x/literal/kind-three items against a scoreboard.
module integer_text_formatter_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS    = 210;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 200;

   typedef struct {
      itf_pkg::kind_type kind;
      logic [7:0]  char_byte;
      logic [31:0] value;
      logic [5:0]  field_width;
      logic        has_precision;
      logic [5:0]  precision;
   } fmt_req_type;

   typedef struct {
      logic [7:0] char_out;
      logic       last;
   } fmt_char_type;

   typedef enum {RX_STEADY, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   class formatter_scoreboard;
      fmt_char_type expected_chars[$];
      int           errors = 0;

      task report(input string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         errors++;
      endtask

      function int pending();
         return expected_chars.size();
      endfunction

      // Render one accepted item into the characters it should produce.
      function void note_item(input fmt_req_type it);
         logic [31:0]  mag;
         logic [31:0]  base;
         logic [3:0]   digs[16];
         int           nd;
         int           zeros;
         int           spaces;
         int           used;
         int           n;
         bit           neg;
         fmt_char_type c;
         nd = 0;
         zeros = 0;
         neg = 1'b0;
         n = 0;
         if (it.kind == itf_pkg::KIND_LITERAL) begin
            c.char_out = it.char_byte;
            c.last = 1'b1;
            expected_chars.push_back(c);
            return;
         end
         if (it.kind == itf_pkg::KIND_DEC || it.kind == itf_pkg::KIND_HEX) begin
            base = (it.kind == itf_pkg::KIND_DEC) ? 32'd10 : 32'd16;
            mag = it.value;
            if (it.kind == itf_pkg::KIND_DEC && it.value[31]) begin
               neg = 1'b1;
               mag = -it.value;
            end
            // least significant digit first
            do begin
               digs[nd] = 4'(mag % base);
               nd++;
               mag = mag / base;
            end while (mag != 0 && nd < 16);
            if (it.has_precision) begin
               if (int'(it.precision) > nd) zeros = int'(it.precision) - nd;
               if (it.precision == 0 && it.value == 0) nd = 0;
            end
         end
         used = zeros + nd + int'(neg);
         spaces = (int'(it.field_width) > used) ? int'(it.field_width) - used : 0;
         c.last = 1'b0;
         c.char_out = itf_pkg::CHAR_SPACE;
         repeat (spaces) begin
            expected_chars.push_back(c);
            n++;
         end
         if (neg) begin
            c.char_out = itf_pkg::CHAR_MINUS;
            expected_chars.push_back(c);
            n++;
         end
         c.char_out = itf_pkg::CHAR_ZERO;
         repeat (zeros) begin
            expected_chars.push_back(c);
            n++;
         end
         for (int i = nd - 1; i >= 0; i--) begin
            c.char_out = (digs[i] < 10) ? 8'h30 + 8'(digs[i]) : 8'h61 + 8'(digs[i]) - 8'd10;
            expected_chars.push_back(c);
            n++;
         end
         if (n > 0) expected_chars[expected_chars.size() - 1].last = 1'b1;
      endfunction

      task check_char(input logic [7:0] char_out, input logic last);
         fmt_char_type exp_c;
         if (expected_chars.size() == 0) begin
            report($sformatf("unexpected char 0x%02h last=%0b", char_out, last));
            return;
         end
         exp_c = expected_chars.pop_front();
         if (char_out !== exp_c.char_out || last !== exp_c.last)
            report($sformatf("char 0x%02h last=%0b, expected 0x%02h last=%0b",
                             char_out, last, exp_c.char_out, exp_c.last));
      endtask
   endclass

   logic clock;
   logic reset;
   bit   hold_off_req;

   itf_req_if req_if();
   itf_rsp_if rsp_if();

   formatter_scoreboard sb = new();

   integer_text_formatter_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic fmt_req_type make_item(input itf_pkg::kind_type kind,
                                             input logic [7:0] char_byte,
                                             input logic [31:0] value, input logic [5:0] fw,
                                             input logic hasp, input logic [5:0] prec);
      fmt_req_type it;
      it.kind = kind;
      it.char_byte = char_byte;
      it.value = value;
      it.field_width = fw;
      it.has_precision = hasp;
      it.precision = prec;
      return it;
   endfunction

   function automatic logic [5:0] rand_size();
      return ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 12));
   endfunction

   function automatic fmt_req_type rand_item();
      fmt_req_type it;
      int          pick;
      logic [31:0] v;
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
         it.kind = itf_pkg::KIND_LITERAL;
      end else if (pick < 6) begin
         it.kind = itf_pkg::KIND_DEC;
      end else if (pick < 9) begin
         it.kind = itf_pkg::KIND_HEX;
      end else begin
         it.kind = itf_pkg::KIND_NONE;
      end
      case ($urandom_range(0, 5))
         0: v = 32'h0;
         1: v = $urandom_range(0, 20);
         2: v = 32'hFFFF_FFFF - $urandom_range(0, 20);
         3: v = 32'h8000_0000 ^ $urandom_range(0, 3);
         default: v = $urandom;
      endcase
      it.char_byte = 8'($urandom);
      it.value = v;
      it.field_width = rand_size();
      it.has_precision = 1'($urandom);
      it.precision = rand_size();
      return it;
   endfunction

   task automatic send_item(input fmt_req_type it);
      req_if.valid <= 1'b1;
      req_if.kind <= it.kind;
      req_if.char_byte <= it.char_byte;
      req_if.value <= it.value;
      req_if.field_width <= it.field_width;
      req_if.has_precision <= it.has_precision;
      req_if.precision <= it.precision;
      do begin
         @(posedge clock);
      end while (!req_if.ready);
      sb.note_item(it);
      @(negedge clock);
   endtask

   // Drop valid only for a real gap, so valid never toggles within one step.
   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         req_if.valid <= 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   function automatic int rand_gap();
      return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
   endfunction

   // Receiver: stall pattern changes per segment; long hold-off on request.
   initial begin
      rx_mode_type mode;
      int          seg_left;
      int          phase;
      int          period;
      logic        rdy;
      seg_left = 0;
      phase = 0;
      period = 2;
      mode = RX_STEADY;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         if (seg_left == 0) begin
            mode = rx_mode_type'($urandom_range(0, 3));
            seg_left = $urandom_range(10, 150);
            period = $urandom_range(2, 8);
            phase = 0;
         end
         seg_left--;
         case (mode)
            RX_STEADY: rdy = 1'b1;
            RX_MOSTLY: rdy = ($urandom_range(0, 3) != 0);
            RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
            default: begin
               rdy = (phase == 0);
               phase = (phase + 1) % period;
            end
         endcase
         rsp_if.ready <= rdy;
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) sb.check_char(rsp_if.char_out, rsp_if.last);
         @(negedge clock);
      end
   end

   initial begin
      fmt_req_type directed[$];
      int          burst;
      reset = 1'b1;
      hold_off_req = 1'b0;
      req_if.valid = 1'b0;
      req_if.kind = itf_pkg::KIND_LITERAL;
      req_if.char_byte = '0;
      req_if.value = '0;
      req_if.field_width = '0;
      req_if.has_precision = 1'b0;
      req_if.precision = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      directed.push_back(make_item(itf_pkg::KIND_LITERAL, 8'h00, 32'h0, 6'd0, 1'b0, 6'd0));
      directed.push_back(make_item(itf_pkg::KIND_LITERAL, 8'hFF, 32'hFFFF_FFFF, 6'd63, 1'b1,
                                   6'd63));
      directed.push_back(make_item(itf_pkg::KIND_LITERAL, 8'h25, 32'h0, 6'd5, 1'b0, 6'd0));
      // zero without precision still prints one digit
      directed.push_back(make_item(itf_pkg::KIND_DEC, 8'h00, 32'h0, 6'd0, 1'b0, 6'd0));
      // zero with precision zero prints nothing but padding
      directed.push_back(make_item(itf_pkg::KIND_DEC, 8'h00, 32'h0, 6'd0, 1'b1, 6'd0));
      directed.push_back(make_item(itf_pkg::KIND_DEC, 8'h00, 32'h0, 6'd5, 1'b1, 6'd0));
      directed.push_back(make_item(itf_pkg::KIND_HEX, 8'h00, 32'h0, 6'd0, 1'b1, 6'd0));
      directed.push_back(make_item(itf_pkg::KIND_HEX, 8'h00, 32'h0, 6'd0, 1'b0, 6'd0));
      // most negative decimal
      directed.push_back(make_item(itf_pkg::KIND_DEC, 8'h00, 32'h8000_0000, 6'd0, 1'b0, 6'd0));
      directed.push_back(make_item(itf_pkg::KIND_DEC, 8'h00, 32'h8000_0000, 6'd63, 1'b1,
                                   6'd63));
      directed.push_back(make_item(itf_pkg::KIND_DEC, 8'h00, 32'h7FFF_FFFF, 6'd63, 1'b1,
                                   6'd63));
      directed.push_back(make_item(itf_pkg::KIND_DEC, 8'h00, 32'hFFFF_FFFF, 6'd63, 1'b1,
                                   6'd63));
      directed.push_back(make_item(itf_pkg::KIND_DEC, 8'h00, 32'hFFFF_FFD6, 6'd10, 1'b1,
                                   6'd5));
      directed.push_back(make_item(itf_pkg::KIND_DEC, 8'h00, 32'd12345, 6'd3, 1'b0, 6'd0));
      directed.push_back(make_item(itf_pkg::KIND_DEC, 8'h00, 32'd1000000000, 6'd0, 1'b0,
                                   6'd0));
      directed.push_back(make_item(itf_pkg::KIND_HEX, 8'h00, 32'hFFFF_FFFF, 6'd0, 1'b0, 6'd0));
      directed.push_back(make_item(itf_pkg::KIND_HEX, 8'h00, 32'hDEAD_BEEF, 6'd20, 1'b1,
                                   6'd12));
      directed.push_back(make_item(itf_pkg::KIND_HEX, 8'h00, 32'hA, 6'd1, 1'b1, 6'd1));
      directed.push_back(make_item(itf_pkg::KIND_HEX, 8'h00, 32'h0123_4567, 6'd63, 1'b1,
                                   6'd63));
      // kind three: spaces only, nothing at all for width zero
      directed.push_back(make_item(itf_pkg::KIND_NONE, 8'hA5, 32'h1234, 6'd0, 1'b1, 6'd9));
      directed.push_back(make_item(itf_pkg::KIND_NONE, 8'h5A, 32'hFFFF_FFFF, 6'd63, 1'b0,
                                   6'd63));
      directed.push_back(make_item(itf_pkg::KIND_NONE, 8'h00, 32'h0, 6'd7, 1'b1, 6'd0));

      foreach (directed[i]) begin
         send_item(directed[i]);
         idle_sender($urandom_range(0, 2));
      end

      burst = 0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // stall the output for a long stretch while items keep coming
         if (i == 40 || i == 150) hold_off_req = 1'b1;
         if (burst == 0) begin
            idle_sender(rand_gap());
            burst = $urandom_range(1, 12);
         end
         send_item(rand_item());
         burst--;
      end
      req_if.valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
